### hw/rtl/b64se_pkg.sv
`timescale 1ns / 1ps

package b64se_pkg;

  // Job queue between the byte front end and the character back end
  localparam int unsigned QueueDepth = 2;

  // Position of the next byte within its three-byte group
  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_e;

  // One queued job: one or two six-bit symbols from a single input byte
  typedef struct packed {
    logic [5:0] sext0;
    logic [5:0] sext1;
    logic       two;   // sext1 is valid
    logic       fin;   // sext1 ends the message
  } job_t;

  // Queue occupancy seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Standard Base64 alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [6:0] b64_char(input logic [5:0] sext);
    logic [6:0] v;
    logic [6:0] ch;
    v = {1'b0, sext};
    if (sext < 6'd26) begin
      ch = 7'd65 + v;
    end else if (sext < 6'd52) begin
      ch = 7'd71 + v;        // 'a' - 26
    end else if (sext < 6'd62) begin
      ch = v - 7'd4;         // '0' - 52
    end else if (sext == 6'd62) begin
      ch = 7'd43;            // '+'
    end else begin
      ch = 7'd47;            // '/'
    end
    return ch;
  endfunction

endpackage

### hw/rtl/b64se_front.sv
`timescale 1ns / 1ps

module b64se_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       data_byte_i,
  input  logic             final_byte_i,
  input  logic             q_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output b64se_pkg::job_t  job_o
);
  import b64se_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  job_t       job;

  // Accept a word whenever the queue has room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Split the byte into symbols according to the group phase
  always_comb begin
    phase_d  = phase_q;
    carry_d  = carry_q;
    job.sext0 = '0;
    job.sext1 = '0;
    job.two   = 1'b0;
    job.fin   = final_byte_i;
    unique case (phase_q)
      PH1: begin
        job.sext0 = {carry_q[1:0], data_byte_i[7:4]};
        if (final_byte_i) begin
          job.sext1 = {data_byte_i[3:0], 2'b00};
          job.two   = 1'b1;
          phase_d   = PH0;
          carry_d   = '0;
        end else begin
          phase_d = PH2;
          carry_d = data_byte_i[3:0];
        end
      end
      PH2: begin
        job.sext0 = {carry_q, data_byte_i[7:6]};
        job.sext1 = data_byte_i[5:0];
        job.two   = 1'b1;
        phase_d   = PH0;
        carry_d   = '0;
      end
      default: begin
        job.sext0 = data_byte_i[7:2];
        if (final_byte_i) begin
          job.sext1 = {data_byte_i[1:0], 4'b0000};
          job.two   = 1'b1;
          phase_d   = PH0;
          carry_d   = '0;
        end else begin
          phase_d = PH1;
          carry_d = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  assign job_o = job;

  // Group state advances only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH0;
      carry_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

### hw/rtl/b64se_queue.sv
`timescale 1ns / 1ps

module b64se_queue #(
  parameter int unsigned Depth = b64se_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64se_pkg::job_t     job_i,
  input  logic                pop_i,
  output b64se_pkg::job_t     job_o,
  output b64se_pkg::q_stat_t  stat_o
);
  import b64se_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign job_o        = slots_q[rd_ptr_q];

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/b64se_back.sv
`timescale 1ns / 1ps

module b64se_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64se_pkg::job_t     job_i,
  input  b64se_pkg::q_stat_t  q_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [6:0]          symbol_char_o,
  output logic                final_symbol_o
);
  import b64se_pkg::*;

  logic       valid_q;
  logic       sel_q, sel_d;   // 1: second symbol of the head job is next
  logic [6:0] char_q;
  logic       fin_q;
  logic       load;
  logic [5:0] sext;
  logic       fin;

  // Output register refills when empty or when its word is taken
  assign load = ~valid_q | ~out_stall_i;

  // Pick the next symbol of the head job
  always_comb begin
    sel_d = sel_q;
    pop_o = 1'b0;
    if (sel_q) begin
      sext = job_i.sext1;
      fin  = job_i.fin;
    end else begin
      sext = job_i.sext0;
      fin  = 1'b0;
    end
    if (load && !q_stat_i.empty) begin
      if (sel_q || !job_i.two) begin
        pop_o = 1'b1;
        sel_d = 1'b0;
      end else begin
        sel_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= ~q_stat_i.empty;
      sel_q   <= sel_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load && !q_stat_i.empty) begin
      char_q <= b64_char(sext);
      fin_q  <= fin;
    end
  end

  assign out_valid_o    = valid_q;
  assign symbol_char_o  = char_q;
  assign final_symbol_o = fin_q;

endmodule

### hw/rtl/base64_stream_encoder_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                 Word
// in       in   in_valid_i / in_stall_o   data_byte_i[7:0], final_byte_i
// out      out  out_valid_o / out_stall_i symbol_char_o[6:0], final_symbol_o
//
// The front end takes one byte per cycle while the job queue has room.
// The back end sends one character per cycle, while out_stall_i is low, from a single
// output register, so a byte that yields two characters (third byte of a group, or the
// final byte) holds the register for both characters in turn.
// A byte's first character passes through the job queue, then the output register.
// Reset clears group phase, queue pointers and the output valid; no clearing pass.
// A stalled output holds its word; stalls reach the input once the queue fills.

module base64_stream_encoder_unit #(
  parameter int unsigned QDepth = b64se_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] symbol_char_o,
  output logic       final_symbol_o
);
  import b64se_pkg::*;

  logic    push;
  logic    pop;
  job_t    job_in;
  job_t    job_head;
  q_stat_t q_stat;

  // Byte front end
  b64se_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_stat.full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .job_o        (job_in)
  );

  // Job queue
  b64se_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_head),
    .stat_o (q_stat)
  );

  // Character back end
  b64se_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_head),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_char_o  (symbol_char_o),
    .final_symbol_o (final_symbol_o)
  );

`ifndef ASSERT_OFF
  // Queue only fills after a push
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !$past(q_stat.full)) |-> $past(push))
    else $error("queue filled without a push");

  // Nothing appears at the output when the queue and register are empty
  a_no_phantom_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.empty && !out_valid_o) |=> !out_valid_o)
    else $error("output word without a queued job");

  // No pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

### sim/base64_stream_encoder_unit_tb.sv
`timescale 1ns / 1ps

module base64_stream_encoder_unit_tb;

  import b64se_pkg::*;

  localparam int unsigned RandomBytes = 400;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam string       Alphabet    =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One character word as seen on the output channel
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } b64_char_t;

  // Directed byte; n_typed > 0 means the characters are given in text
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [1:0]  n_typed;
    logic [15:0] text;
  } byte_row_t;

  localparam int unsigned NumRows = 23;
  localparam byte_row_t ByteRows [NumRows] = '{
    // lone zero byte, flushed at once
    '{8'h00, 1'b1, 2'd2, "AA"},
    // lone all-ones byte
    '{8'hFF, 1'b1, 2'd2, "/w"},
    // full group of ones, final lands on the group's last char
    '{8'hFF, 1'b0, 2'd1, 16'("/")},
    '{8'hFF, 1'b0, 2'd1, 16'("/")},
    '{8'hFF, 1'b1, 2'd2, "//"},
    // full group of zeros, message left open
    '{8'h00, 1'b0, 2'd1, 16'("A")},
    '{8'h00, 1'b0, 2'd1, 16'("A")},
    '{8'h00, 1'b0, 2'd2, "AA"},
    // digit seven in the alphabet
    '{8'hEC, 1'b1, 2'd2, "7A"},
    // two-byte messages, final in the middle phase
    '{8'h4D, 1'b0, 2'd0, 16'h0},
    '{8'h61, 1'b1, 2'd0, 16'h0},
    '{8'h00, 1'b0, 2'd0, 16'h0},
    '{8'hFF, 1'b1, 2'd0, 16'h0},
    // three-byte text with final on the third byte
    '{8'h4D, 1'b0, 2'd0, 16'h0},
    '{8'h61, 1'b0, 2'd0, 16'h0},
    '{8'h6E, 1'b1, 2'd0, 16'h0},
    // plus and slash characters
    '{8'hFB, 1'b0, 2'd0, 16'h0},
    '{8'hFF, 1'b0, 2'd0, 16'h0},
    '{8'hBF, 1'b1, 2'd0, 16'h0},
    // carry bits at the top and bottom
    '{8'h80, 1'b0, 2'd0, 16'h0},
    '{8'h01, 1'b1, 2'd0, 16'h0},
    '{8'hFF, 1'b0, 2'd0, 16'h0},
    '{8'hFF, 1'b1, 2'd0, 16'h0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [6:0] symbol_char_o;
  logic       final_symbol_o;

  // Encoder model state
  phase_e     grp_phase;
  logic [3:0] left_bits;
  b64_char_t  pending_chars[$];

  int unsigned err_count  = 0;
  int unsigned idle_count = 0;
  int unsigned byte_count = 0;
  bit          steady     = 1'b0;

  base64_stream_encoder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .symbol_char_o (symbol_char_o),
    .final_symbol_o(final_symbol_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Mostly back-to-back, some short holes, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_char(input bit keep, input logic [5:0] sextet, input logic last);
    b64_char_t c;
    c.ch   = 7'(Alphabet[sextet]);
    c.last = last;
    if (keep) begin
      pending_chars.push_back(c);
    end
  endtask

  // Expected characters for one accepted byte
  task automatic encode_byte(input logic [7:0] b, input logic fin, input bit keep);
    case (grp_phase)
      PH1: begin
        queue_char(keep, {left_bits[1:0], b[7:4]}, 1'b0);
        if (fin) begin
          queue_char(keep, {b[3:0], 2'b00}, 1'b1);
          grp_phase = PH0;
          left_bits = '0;
        end else begin
          left_bits = b[3:0];
          grp_phase = PH2;
        end
      end
      PH2: begin
        queue_char(keep, {left_bits, b[7:6]}, 1'b0);
        queue_char(keep, b[5:0], fin);
        grp_phase = PH0;
        left_bits = '0;
      end
      default: begin
        queue_char(keep, b[7:2], 1'b0);
        if (fin) begin
          queue_char(keep, {b[1:0], 4'b0000}, 1'b1);
          grp_phase = PH0;
          left_bits = '0;
        end else begin
          left_bits = {2'b00, b[1:0]};
          grp_phase = PH1;
        end
      end
    endcase
  endtask

  // Present one word and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit keep);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    encode_byte(b, fin, keep);
    byte_count++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 8'h00;
    end else if (r < 30) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Stimulus
  initial begin
    b64_char_t   c;
    int unsigned msg_len;
    int unsigned r;
    int unsigned next_pause;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    data_byte_i  <= '0;
    final_byte_i <= 1'b0;
    grp_phase     = PH0;
    left_bits     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (ByteRows[i]) begin
      send_byte(ByteRows[i].data, ByteRows[i].fin, ByteRows[i].n_typed == 2'd0);
      if (ByteRows[i].n_typed == 2'd2) begin
        c.ch   = ByteRows[i].text[14:8];
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      if (ByteRows[i].n_typed != 2'd0) begin
        c.ch   = ByteRows[i].text[6:0];
        c.last = ByteRows[i].fin;
        pending_chars.push_back(c);
      end
    end
    wait_drained();

    // random messages, each closed by a final byte
    byte_count = 0;
    next_pause = 100;
    while (byte_count < RandomBytes) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        msg_len = $urandom_range(1, 6);
      end else if (r < 95) begin
        msg_len = $urandom_range(7, 20);
      end else begin
        msg_len = $urandom_range(21, 60);
      end
      steady = ($urandom_range(0, 4) == 0);
      for (int unsigned k = 1; k <= msg_len; k++) begin
        send_byte(pick_byte(), k == msg_len, 1'b1);
      end
      if (byte_count >= next_pause) begin
        wait_drained();
        next_pause += 100;
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("base64_stream_encoder_unit regression: pass");
    end else begin
      $display("base64_stream_encoder_unit regression: fail");
    end
    $finish;
  end

  // Output stall pattern
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      hold = pick_gap();
      if (hold == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check each accepted character against the oldest expected one
  always @(posedge clk_i) begin
    b64_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch("unexpected char", int'(symbol_char_o), 0);
      end else begin
        want = pending_chars.pop_front();
        if (symbol_char_o !== want.ch) begin
          flag_mismatch("symbol_char", int'(symbol_char_o), int'(want.ch));
        end
        if (final_symbol_o !== want.last) begin
          flag_mismatch("final_symbol", int'(final_symbol_o), int'(want.last));
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= IdleLimit) begin
      $display("base64_stream_encoder_unit regression: fail");
      $finish;
    end
  end

endmodule

### base64_stream_encoder_unit.f
hw/rtl/b64se_pkg.sv
hw/rtl/b64se_front.sv
hw/rtl/b64se_queue.sv
hw/rtl/b64se_back.sv
hw/rtl/base64_stream_encoder_unit.sv
sim/base64_stream_encoder_unit_tb.sv
